// File: rtl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// shared types, letter codes and key square helpers for the digraph cipher
// ----------------------------------------------------------------------------
package pfc_pkg;

    // geometry of the key square
    localparam int SQUARE_SIDE = 5;
    localparam int LETTER_W    = 5;
    localparam int ROW_W       = SQUARE_SIDE * LETTER_W;
    localparam int IDX_W       = $clog2(SQUARE_SIDE);

    // default depth of the pair queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // letter codes
    localparam logic [LETTER_W-1:0] CODE_I = 5'd8;
    localparam logic [LETTER_W-1:0] CODE_J = 5'd9;
    localparam logic [LETTER_W-1:0] CODE_X = 5'd23;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROW4 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE = 3'd5;

    // key square, row 0 first, column 0 in the low bits of each row
    typedef logic [SQUARE_SIDE-1:0][ROW_W-1:0] square_t;

    // one digraph waiting to be transformed
    typedef struct packed {
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
        logic                last;
    } pair_t;

    // write request from the front into the queue
    typedef struct packed {
        logic wr0;
        logic wr1;
    } push_t;

    // position of a letter in the square
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } loc_t;

    // letter held at a given row and column
    function automatic logic [LETTER_W-1:0] cell_at(input square_t sq,
                                                    input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
        return sq[r][c*LETTER_W +: LETTER_W];
    endfunction

    // first match in row-major order wins, so scan backwards and overwrite
    function automatic loc_t locate(input square_t sq, input logic [LETTER_W-1:0] code);
        loc_t res;
        res = '0;
        for (int r = SQUARE_SIDE - 1; r >= 0; r--) begin
            for (int c = SQUARE_SIDE - 1; c >= 0; c--) begin
                if (sq[r][c*LETTER_W +: LETTER_W] == code) begin
                    res.found = 1'b1;
                    res.row   = IDX_W'(r);
                    res.col   = IDX_W'(c);
                end
            end
        end
        return res;
    endfunction

    // wrapping step by one, forwards when encrypting, backwards otherwise
    function automatic logic [IDX_W-1:0] shift_one(input logic [IDX_W-1:0] v,
                                                   input logic enc);
        logic [IDX_W-1:0] res;
        if (enc) begin
            res = (v == IDX_W'(SQUARE_SIDE - 1)) ? '0 : v + IDX_W'(1);
        end else begin
            res = (v == '0) ? IDX_W'(SQUARE_SIDE - 1) : v - IDX_W'(1);
        end
        return res;
    endfunction

endpackage

// File: rtl/pfc_front.sv
// ----------------------------------------------------------------------------
// pfc_front
// folds J to I, holds a lone first letter and groups letters into digraphs
// ----------------------------------------------------------------------------
module pfc_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         accept,
    input  logic [pfc_pkg::LETTER_W-1:0] letter,
    input  logic                         end_of_text,
    output pfc_pkg::push_t               push,
    output pfc_pkg::pair_t               pair0,
    output pfc_pkg::pair_t               pair1
);
    import pfc_pkg::*;

    logic                pend_valid_reg, pend_valid_next;
    logic [LETTER_W-1:0] pend_letter_reg, pend_letter_next;
    logic [LETTER_W-1:0] folded;

    assign folded = (letter == CODE_J) ? CODE_I : letter;

    // pairing decision for the accepted letter
    always_comb begin
        pend_valid_next  = pend_valid_reg;
        pend_letter_next = pend_letter_reg;
        push             = '0;
        pair0            = '{first: pend_letter_reg, second: CODE_X, last: 1'b1};
        pair1            = '{first: folded, second: CODE_X, last: 1'b1};
        if (accept) begin
            if (!pend_valid_reg) begin
                if (end_of_text) begin
                    push.wr0 = 1'b1;
                    pair0    = '{first: folded, second: CODE_X, last: 1'b1};
                end else begin
                    pend_valid_next  = 1'b1;
                    pend_letter_next = folded;
                end
            end else if (folded != pend_letter_reg) begin
                push.wr0         = 1'b1;
                pair0.second     = folded;
                pend_valid_next  = 1'b0;
                pend_letter_next = '0;
            end else if (!end_of_text) begin
                // doubled letter: pad with X and keep the letter held
                push.wr0 = 1'b1;
            end else begin
                // doubled final letter gives two padded digraphs
                push.wr0         = 1'b1;
                push.wr1         = 1'b1;
                pair0.last       = 1'b0;
                pend_valid_next  = 1'b0;
                pend_letter_next = '0;
            end
        end
    end

    // held letter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg  <= 1'b0;
            pend_letter_reg <= '0;
        end else begin
            pend_valid_reg  <= pend_valid_next;
            pend_letter_reg <= pend_letter_next;
        end
    end

endmodule

// File: rtl/pfc_queue.sv
// ----------------------------------------------------------------------------
// pfc_queue
// small digraph queue taking up to two entries and giving one per cycle while popped
// ----------------------------------------------------------------------------
module pfc_queue #(
    parameter int DEPTH = pfc_pkg::QUEUE_DEPTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  pfc_pkg::push_t            push,
    input  pfc_pkg::pair_t            pair0,
    input  pfc_pkg::pair_t            pair1,
    input  logic                      pop,
    output pfc_pkg::pair_t            head,
    output logic                      not_empty,
    output logic                      has_room,
    output logic [$clog2(DEPTH+1)-1:0] level
);
    import pfc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pair_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign has_room  = (count_reg <= CNT_W'(DEPTH - 2));
    assign level     = count_reg;

    // pointer and fill arithmetic
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.wr0) + PTR_W'(push.wr1);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.wr0) + CNT_W'(push.wr1) - CNT_W'(pop);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push.wr0) begin
            entry_reg[wr_ptr_reg] <= pair0;
        end
        if (push.wr1) begin
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= pair1;
        end
    end

endmodule

// File: rtl/pfc_back.sv
// ----------------------------------------------------------------------------
// pfc_back
// locates a digraph in the key square and registers the transformed pair
// ----------------------------------------------------------------------------
module pfc_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pfc_pkg::square_t             square,
    input  logic                         encrypt,
    input  pfc_pkg::pair_t               head,
    input  logic                         not_empty,
    output logic                         pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,
    output logic                         m_tuser,
    output logic                         m_tlast
);
    import pfc_pkg::*;

    loc_t                loc_a, loc_b;
    logic                ok;
    logic [IDX_W-1:0]    r1, c1, r2, c2;
    logic [LETTER_W-1:0] res_first, res_second;

    logic                out_valid_reg, out_valid_next;
    logic [LETTER_W-1:0] out_first_reg, out_second_reg;
    logic                out_bad_reg, out_last_reg;

    assign pop = not_empty && (!out_valid_reg || m_tready);

    // square lookup and row, column or rectangle rule
    always_comb begin
        loc_a = locate(square, head.first);
        loc_b = locate(square, head.second);
        ok    = (head.first != head.second) && loc_a.found && loc_b.found;
        r1    = loc_a.row;
        c1    = loc_a.col;
        r2    = loc_b.row;
        c2    = loc_b.col;
        if (loc_a.row == loc_b.row) begin
            c1 = shift_one(loc_a.col, encrypt);
            c2 = shift_one(loc_b.col, encrypt);
        end else if (loc_a.col == loc_b.col) begin
            r1 = shift_one(loc_a.row, encrypt);
            r2 = shift_one(loc_b.row, encrypt);
        end else begin
            c1 = loc_b.col;
            c2 = loc_a.col;
        end
        res_first  = ok ? cell_at(square, r1, c1) : '0;
        res_second = ok ? cell_at(square, r2, c2) : '0;
    end

    // output register valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            out_first_reg  <= res_first;
            out_second_reg <= res_second;
            out_bad_reg    <= !ok;
            out_last_reg   <= head.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_second_reg, out_first_reg};
    assign m_tuser  = out_bad_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/playfair_digraph_cipher.sv
// a result is written to the pair queue, then to the output register, after the letter that completes its digraph
// throughput: one letter per cycle while the pair queue has room; a doubled final letter yields two results,
//   drained one per cycle by the back end when m_tready is high, while the pair queue absorbs the extra
// the input stalls only when the pair queue lacks room for two digraphs
// reset clears the held letter, the queue, the output register and the key
//   square, and selects encryption
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// letter stream to digraph cipher over a configurable 5x5 key square
// ----------------------------------------------------------------------------
module playfair_digraph_cipher #(
    parameter int QUEUE_DEPTH = pfc_pkg::QUEUE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // letter stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [4:0] letter
    input  logic                          s_tlast,   // end of text
    // digraph stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // [4:0] out_first, [9:5] out_second
    output logic                          m_tuser,   // [0] bad_pair
    output logic                          m_tlast,   // last of run
    // configuration writes
    input  logic                          cfg_wr_en,
    input  logic [pfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pfc_pkg::ROW_W-1:0]     cfg_data
);
    import pfc_pkg::*;

    square_t                        square_reg;
    logic                           encrypt_reg;
    push_t                          push;
    pair_t                          pair0, pair1, head;
    logic                           s_accept, pop, not_empty, has_room;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] level;

    assign s_tready = has_room;
    assign s_accept = s_tvalid && has_room;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            square_reg  <= '0;
            encrypt_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index) inside
                [CFG_IDX_ROW0:CFG_IDX_ROW4]: square_reg[cfg_index] <= cfg_data;
                CFG_IDX_MODE:                encrypt_reg <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    // pairing front end
    pfc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_accept),
        .letter      (s_tdata[LETTER_W-1:0]),
        .end_of_text (s_tlast),
        .push        (push),
        .pair0       (pair0),
        .pair1       (pair1)
    );

    // digraph queue
    pfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pair0     (pair0),
        .pair1     (pair1),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .has_room  (has_room),
        .level     (level)
    );

    // transform back end
    pfc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .square    (square_reg),
        .encrypt   (encrypt_reg),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // a second digraph is only ever written alongside a first
    a_push_order: assert property (@(posedge aclk) disable iff (!aresetn)
        push.wr1 |-> push.wr0)
        else $error("second digraph pushed without first");

    // queue never holds more than its depth
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
        else $error("pair queue overfilled");

    // a bad pair carries zero letters
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("bad pair with non-zero letters");

    // popping requires a queued digraph
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (level != '0))
        else $error("pop from empty pair queue");

endmodule

// File: tb/playfair_digraph_cipher_tb.sv
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_tb
// self-checking bench for the letter-stream digraph cipher: letters go in on
// the slave stream, every digraph coming out is compared field by field with
// a behavioural copy of the pairing and key-square lookup or with a scripted answer, under a series of
// key squares and both directions, with random gaps on both streams
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfc_pkg::*;

    // one transformed digraph as it leaves the block
    typedef struct packed {
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
        logic                bad;
        logic                last;
    } digraph_t;

    // one row of the directed script; typed rows carry their own answer
    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                eot;
        logic                typed;
        logic [1:0]          count;
        digraph_t            want0;
        digraph_t            want1;
    } script_row_t;

    // key square layouts used by the configuration phases
    localparam int LAYOUT_PLAIN    = 0;
    localparam int LAYOUT_SHUFFLED = 1;
    localparam int LAYOUT_FLAWED   = 2;
    localparam int LAYOUT_NOISE    = 3;
    localparam int LAYOUT_EXTREME  = 4;

    localparam int    CELLS        = SQUARE_SIDE * SQUARE_SIDE;
    localparam int    RANDOM_ITEMS = 1400;
    localparam int    TAIL_ITEMS   = 150;
    localparam int    SETTLE       = 4;
    localparam time   RUN_LIMIT    = 10ms;

    localparam logic [ROW_W-1:0] ROW_ONES = '1;

    // letter codes used in the script
    localparam logic [LETTER_W-1:0] LTR_A    = 5'd0;
    localparam logic [LETTER_W-1:0] LTR_B    = 5'd1;
    localparam logic [LETTER_W-1:0] LTR_E    = 5'd4;
    localparam logic [LETTER_W-1:0] LTR_G    = 5'd6;
    localparam logic [LETTER_W-1:0] LTR_K    = 5'd10;
    localparam logic [LETTER_W-1:0] LTR_L    = 5'd11;
    localparam logic [LETTER_W-1:0] LTR_M    = 5'd12;
    localparam logic [LETTER_W-1:0] LTR_V    = 5'd21;
    localparam logic [LETTER_W-1:0] LTR_Z    = 5'd25;
    localparam logic [LETTER_W-1:0] LTR_PAST = 5'd26;
    localparam logic [LETTER_W-1:0] LTR_TOP  = 5'd31;

    localparam digraph_t NO_DIGRAPH = '0;
    localparam digraph_t BAD_LAST   = '{first: '0, second: '0, bad: 1'b1, last: 1'b1};
    localparam digraph_t BAD_MORE   = '{first: '0, second: '0, bad: 1'b1, last: 1'b0};

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;    // [4:0] letter
    logic                 s_tlast   = 1'b0;  // end of text
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [15:0]          m_tdata;           // [4:0] out_first, [9:5] out_second
    logic                 m_tuser;           // [0] bad_pair
    logic                 m_tlast;           // last of run
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ROW_W-1:0]     cfg_data  = '0;

    // shadow of the block: key square, direction and the held letter
    logic [ROW_W-1:0]    key_rows [SQUARE_SIDE] = '{default: '0};
    logic                encrypting  = 1'b1;
    logic                held_valid  = 1'b0;
    logic [LETTER_W-1:0] held_letter = '0;

    logic [LETTER_W-1:0] layout [CELLS];
    digraph_t            digraphs_due [$];
    int                  mismatches = 0;
    logic                calm = 1'b0;

    // opening rows, run on the all-zero square left by reset
    script_row_t reset_rows [0:5] = '{
        '{LTR_A,   1'b0, 1'b1, 2'd0, NO_DIGRAPH, NO_DIGRAPH},
        '{LTR_B,   1'b0, 1'b1, 2'd1, BAD_LAST,   NO_DIGRAPH},
        '{LTR_Z,   1'b1, 1'b1, 2'd1, BAD_LAST,   NO_DIGRAPH},
        '{LTR_TOP, 1'b1, 1'b1, 2'd1, BAD_LAST,   NO_DIGRAPH},
        '{CODE_J,  1'b0, 1'b1, 2'd0, NO_DIGRAPH, NO_DIGRAPH},
        '{CODE_J,  1'b1, 1'b1, 2'd2, BAD_MORE,   BAD_LAST}
    };

    // rows on the alphabetic square, answers come from the shadow model
    script_row_t keyed_rows [0:15] = '{
        '{LTR_E,    1'b0, 1'b0, 2'd0, NO_DIGRAPH, NO_DIGRAPH},  // same row, wraps
        '{LTR_A,    1'b0, 1'b0, 2'd0, NO_DIGRAPH, NO_DIGRAPH},
        '{LTR_V,    1'b0, 1'b0, 2'd0, NO_DIGRAPH, NO_DIGRAPH},  // same column, wraps
        '{LTR_A,    1'b0, 1'b0, 2'd0, NO_DIGRAPH, NO_DIGRAPH},
        '{LTR_A,    1'b0, 1'b0, 2'd0, NO_DIGRAPH, NO_DIGRAPH},  // rectangle
        '{LTR_G,    1'b0, 1'b0, 2'd0, NO_DIGRAPH, NO_DIGRAPH},
        '{CODE_J,   1'b0, 1'b0, 2'd0, NO_DIGRAPH, NO_DIGRAPH},  // J folds onto I
        '{LTR_K,    1'b0, 1'b0, 2'd0, NO_DIGRAPH, NO_DIGRAPH},
        '{LTR_L,    1'b0, 1'b0, 2'd0, NO_DIGRAPH, NO_DIGRAPH},  // doubled, stays held
        '{LTR_L,    1'b0, 1'b0, 2'd0, NO_DIGRAPH, NO_DIGRAPH},
        '{LTR_M,    1'b0, 1'b0, 2'd0, NO_DIGRAPH, NO_DIGRAPH},
        '{LTR_Z,    1'b0, 1'b0, 2'd0, NO_DIGRAPH, NO_DIGRAPH},  // doubled at the end
        '{LTR_Z,    1'b1, 1'b0, 2'd0, NO_DIGRAPH, NO_DIGRAPH},
        '{LTR_PAST, 1'b0, 1'b0, 2'd0, NO_DIGRAPH, NO_DIGRAPH},  // code past the alphabet
        '{LTR_B,    1'b0, 1'b0, 2'd0, NO_DIGRAPH, NO_DIGRAPH},
        '{CODE_X,   1'b1, 1'b0, 2'd0, NO_DIGRAPH, NO_DIGRAPH}   // lone X pairs with itself
    };

    playfair_digraph_cipher i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // shadow model
    // ------------------------------------------------------------------------

    function automatic logic [LETTER_W-1:0] square_cell(input int r, input int c);
        return key_rows[r][c*LETTER_W +: LETTER_W];
    endfunction

    // earliest cell in row-major order holding the code
    function automatic logic find_letter(input logic [LETTER_W-1:0] code,
                                         output int r, output int c);
        logic hit;
        hit = 1'b0;
        r = 0;
        c = 0;
        for (int i = 0; i < CELLS; i++) begin
            if (!hit && square_cell(i / SQUARE_SIDE, i % SQUARE_SIDE) == code) begin
                hit = 1'b1;
                r = i / SQUARE_SIDE;
                c = i % SQUARE_SIDE;
            end
        end
        return hit;
    endfunction

    function automatic int step_index(input int v);
        return encrypting ? (v + 1) % SQUARE_SIDE : (v + SQUARE_SIDE - 1) % SQUARE_SIDE;
    endfunction

    // key square lookup of one digraph
    function automatic digraph_t cipher_pair(input logic [LETTER_W-1:0] a,
                                             input logic [LETTER_W-1:0] b);
        digraph_t d;
        int       r1, c1, r2, c2;
        logic     in_a, in_b;
        d = '0;
        in_a = find_letter(a, r1, c1);
        in_b = find_letter(b, r2, c2);
        if (a == b || !in_a || !in_b) begin
            d.bad = 1'b1;
        end else if (r1 == r2) begin
            d.first  = square_cell(r1, step_index(c1));
            d.second = square_cell(r2, step_index(c2));
        end else if (c1 == c2) begin
            d.first  = square_cell(step_index(r1), c1);
            d.second = square_cell(step_index(r2), c2);
        end else begin
            d.first  = square_cell(r1, c2);
            d.second = square_cell(r2, c1);
        end
        return d;
    endfunction

    // pairing of the letter stream; returns how many digraphs the letter yields
    function automatic int advance_cipher(input logic [LETTER_W-1:0] letter,
                                          input logic eot,
                                          output digraph_t d0, output digraph_t d1);
        logic [LETTER_W-1:0] code;
        int                  n;
        code = (letter == CODE_J) ? CODE_I : letter;
        n = 0;
        d0 = '0;
        d1 = '0;
        if (!held_valid) begin
            if (eot) begin
                d0 = cipher_pair(code, CODE_X);
                n = 1;
            end else begin
                held_valid  = 1'b1;
                held_letter = code;
            end
        end else if (code != held_letter) begin
            d0 = cipher_pair(held_letter, code);
            n = 1;
            held_valid  = 1'b0;
            held_letter = '0;
        end else begin
            d0 = cipher_pair(held_letter, CODE_X);
            n = 1;
            if (eot) begin
                d1 = cipher_pair(code, CODE_X);
                n = 2;
                held_valid  = 1'b0;
                held_letter = '0;
            end
        end
        if (n == 1) begin
            d0.last = 1'b1;
        end else if (n == 2) begin
            d1.last = 1'b1;
        end
        return n;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // one register write; enable is left high for the caller to drop
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        if (idx <= CFG_IDX_ROW4) begin
            key_rows[idx] = value;
        end else if (idx == CFG_IDX_MODE) begin
            encrypting = value[0];
        end
        @(negedge aclk);
    endtask

    // load a key square and direction while the block is idle
    task automatic configure_phase(input int kind, input logic mode);
        int                  j;
        logic [LETTER_W-1:0] spare;
        logic [ROW_W-1:0]    row;
        j = 0;
        for (int code = 0; code < 26; code++) begin
            if (code != CODE_J) begin
                layout[j] = code[LETTER_W-1:0];
                j++;
            end
        end
        if (kind != LAYOUT_PLAIN) begin
            for (int i = CELLS - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                spare = layout[i];
                layout[i] = layout[j];
                layout[j] = spare;
            end
        end
        // a repeated letter or a J cell in an otherwise clean square
        if (kind == LAYOUT_FLAWED) begin
            j = $urandom_range(0, CELLS - 1);
            layout[j] = $urandom_range(0, 1) ? CODE_J : layout[$urandom_range(0, CELLS - 1)];
        end
        if (kind == LAYOUT_NOISE) begin
            foreach (layout[i]) layout[i] = LETTER_W'($urandom_range(0, 31));
        end
        for (int r = 0; r < SQUARE_SIDE; r++) begin
            for (int c = 0; c < SQUARE_SIDE; c++) begin
                row[c*LETTER_W +: LETTER_W] = layout[r*SQUARE_SIDE + c];
            end
            // all-zero and all-ones rows, both present in every such square
            if (kind == LAYOUT_EXTREME) begin
                if (r == 0) begin
                    row = '0;
                end else if (r == SQUARE_SIDE - 1) begin
                    row = ROW_ONES;
                end else begin
                    row = $urandom_range(0, 1) ? ROW_ONES : '0;
                end
            end
            write_reg(CFG_IDX_ROW0 + CFG_IDX_W'(r), row);
        end
        write_reg(CFG_IDX_MODE, {ROW_W'($urandom) & ~ROW_W'(1)} | ROW_W'(mode));
        // indexes past the mode register must change nothing
        write_reg(CFG_IDX_MODE + CFG_IDX_W'(1 + $urandom_range(0, 1)), ROW_W'($urandom));
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // offer one letter and book what it should produce
    task automatic send_row(input script_row_t row);
        digraph_t d0, d1;
        int       n;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, row.letter};
        s_tlast  <= row.eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n = advance_cipher(row.letter, row.eot, d0, d1);
        if (row.typed) begin
            n  = int'(row.count);
            d0 = row.want0;
            d1 = row.want1;
        end
        if (n > 0) digraphs_due.push_back(d0);
        if (n > 1) digraphs_due.push_back(d1);
        @(negedge aclk);
    endtask

    // sender gap with junk on the data lines
    task automatic pause_sender();
        s_tvalid <= 1'b0;
        s_tdata  <= {3'b000, LETTER_W'($urandom)};
        s_tlast  <= 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 18)) @(negedge aclk);
    endtask

    // stop sending until every booked digraph has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (digraphs_due.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // receiver: ready with random stall bursts
    // ------------------------------------------------------------------------
    initial begin : ready_gen
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // digraph checker
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : digraph_check
        digraph_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (digraphs_due.size() == 0) begin
                note_mismatch("digraph with none due, out_first", int'(m_tdata[4:0]), 0);
            end else begin
                want = digraphs_due.pop_front();
                if (m_tdata[4:0] !== want.first)
                    note_mismatch("out_first", int'(m_tdata[4:0]), int'(want.first));
                if (m_tdata[9:5] !== want.second)
                    note_mismatch("out_second", int'(m_tdata[9:5]), int'(want.second));
                if (m_tuser !== want.bad)
                    note_mismatch("bad_pair", int'(m_tuser), int'(want.bad));
                if (m_tlast !== want.last)
                    note_mismatch("last_of_run", int'(m_tlast), int'(want.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        script_row_t         row;
        int                  sent, span, phase, pick, kind;
        logic                tail;
        logic [LETTER_W-1:0] prev;

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset square, then the alphabetic square both ways
        foreach (reset_rows[i]) send_row(reset_rows[i]);
        drain_results();
        configure_phase(LAYOUT_PLAIN, 1'b1);
        foreach (keyed_rows[i]) send_row(keyed_rows[i]);
        drain_results();
        configure_phase(LAYOUT_PLAIN, 1'b0);
        for (int i = 0; i < 4; i++) send_row(keyed_rows[i]);
        drain_results();

        // random phases, each with a fresh square; the tail runs without gaps
        sent  = 0;
        phase = 0;
        prev  = '0;
        while (sent < RANDOM_ITEMS) begin
            tail = (sent >= RANDOM_ITEMS - TAIL_ITEMS);
            if (tail) begin
                span = RANDOM_ITEMS - sent;
            end else begin
                span = $urandom_range(40, 120);
                if (span > RANDOM_ITEMS - TAIL_ITEMS - sent)
                    span = RANDOM_ITEMS - TAIL_ITEMS - sent;
            end
            calm = tail || ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if (phase == 0)     kind = LAYOUT_EXTREME;
            else if (pick < 6)  kind = LAYOUT_SHUFFLED;
            else if (pick == 6) kind = LAYOUT_FLAWED;
            else if (pick == 7) kind = LAYOUT_NOISE;
            else if (pick == 8) kind = LAYOUT_EXTREME;
            else                kind = LAYOUT_PLAIN;
            configure_phase(kind, 1'($urandom_range(0, 1)));
            repeat (span) begin
                if (!calm && $urandom_range(0, 5) == 0) pause_sender();
                row = '0;
                if ($urandom_range(0, 5) == 0) begin
                    row.letter = prev;
                end else if ($urandom_range(0, 15) == 0) begin
                    row.letter = LETTER_W'($urandom_range(26, 31));
                end else begin
                    row.letter = LETTER_W'($urandom_range(0, 25));
                end
                row.eot = ($urandom_range(0, 7) == 0);
                prev = row.letter;
                send_row(row);
                sent++;
            end
            drain_results();
            phase++;
        end

        if (mismatches == 0) begin
            $display("playfair_digraph_cipher_tb: clean");
        end else begin
            $display("playfair_digraph_cipher_tb: errors");
        end
        $finish;
    end

    // hang guard
    initial begin : watchdog
        #(RUN_LIMIT);
        $display("playfair_digraph_cipher_tb: errors");
        $finish;
    end

endmodule
